FILE: design/iec_bd_pkg.sv
// ----------------------------------------------------------------------------
// iec_bd_pkg
// shared types and constants for the burst deformatter
// ----------------------------------------------------------------------------
package iec_bd_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned SIZE_W = 15;
  localparam int unsigned IDX_W  = 2;

  localparam logic [WORD_W-1:0] SYNC_A     = 16'hF872;
  localparam logic [WORD_W-1:0] SYNC_B     = 16'h4E1F;
  localparam logic [WORD_W-1:0] FRAME_MARK = 16'h770B;
  localparam logic [WORD_W-1:0] PREAMBLE_WORDS = 16'd4;

  localparam logic [WORD_W-1:0] RST_ENH_CODE  = 16'd21;
  localparam logic [SIZE_W-1:0] RST_PLAIN_SZ  = 15'd3072;
  localparam logic [SIZE_W-1:0] RST_ENH_SZ    = 15'd12288;

  typedef enum logic [IDX_W-1:0] {
    REG_ENH_CODE  = 2'd0,
    REG_PLAIN_SZ  = 2'd1,
    REG_ENH_SZ    = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_SEARCH_A = 3'd0,
    PH_SEARCH_B = 3'd1,
    PH_PC       = 3'd2,
    PH_PD       = 3'd3,
    PH_FIRST    = 3'd4,
    PH_PAYLOAD  = 3'd5,
    PH_SKIP     = 3'd6
  } phase_t;

endpackage

FILE: design/iec_burst_deformatter_top.sv
// ----------------------------------------------------------------------------
// iec_burst_deformatter_top
// finds framed bursts in a word stream and passes byte-swapped payload beats
// ----------------------------------------------------------------------------
// path: an input beat goes through the input register, then the result register;
//   one word is taken per cycle while the output drains
// throughput: at most one beat per cycle while out_ready holds, set by the single state update per word
// reset: rst (synchronous) returns to preamble search and restores the
//   register defaults; no clearing pass is needed
module iec_burst_deformatter_top
  import iec_bd_pkg::*;
#(
  parameter int unsigned MAX_BURST_WORDS = 16384
) (
  input  logic                clk,
  input  logic                rst,
  // word stream in
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [WORD_W-1:0]   in_word,
  // payload out
  output logic                out_valid,
  input  logic                out_ready,
  output logic [WORD_W-1:0]   out_word,
  output logic                last_of_frame,
  // register writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [WORD_W-1:0]   cfg_data
);

  // counters only need to hold the room after the preamble
  localparam int unsigned CNT_W = $clog2(MAX_BURST_WORDS);
  localparam logic [WORD_W-1:0] MaxWords = WORD_W'(MAX_BURST_WORDS);

  // burst size to room after the preamble, size clamped to the maximum
  function automatic logic [CNT_W-1:0] room_of(input logic [SIZE_W-1:0] size);
    logic [WORD_W-1:0] sz;
    logic [WORD_W-1:0] rm;
    sz = {1'b0, size};
    if (sz > MaxWords) sz = MaxWords;
    rm = (sz > PREAMBLE_WORDS) ? (sz - PREAMBLE_WORDS) : '0;
    return rm[CNT_W-1:0];
  endfunction

  // configuration: sizes kept as precomputed room
  logic [WORD_W-1:0] enh_code;
  logic [CNT_W-1:0]  plain_room;
  logic [CNT_W-1:0]  enh_room;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enh_code   <= RST_ENH_CODE;
      plain_room <= room_of(RST_PLAIN_SZ);
      enh_room   <= room_of(RST_ENH_SZ);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_ENH_CODE: enh_code   <= cfg_data;
        REG_PLAIN_SZ: plain_room <= room_of(cfg_data[SIZE_W-1:0]);
        REG_ENH_SZ:   enh_room   <= room_of(cfg_data[SIZE_W-1:0]);
        default: ;   // writes past the list are dropped
      endcase
    end
  end

  // input register
  logic              in_full;
  logic [WORD_W-1:0] in_hold;
  logic              advance;

  // the held word moves on when the result register is free or draining
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_hold <= in_word;
    end
  end

  // burst state
  phase_t            phase, phase_next;
  logic              is_enhanced, is_enhanced_next;
  logic [CNT_W-1:0]  payload_left, payload_left_next;
  logic [CNT_W-1:0]  burst_left, burst_left_next;
  logic              pass_frame, pass_frame_next;

  logic [WORD_W-1:0] swapped;
  logic [WORD_W-1:0] pd_count;
  logic [WORD_W-1:0] pd_room;
  logic [CNT_W-1:0]  clamped;
  logic [CNT_W-1:0]  pay_dec;
  logic [CNT_W-1:0]  burst_dec;
  logic              emit;

  assign swapped = {in_hold[7:0], in_hold[15:8]};

  // length word: bytes for enhanced bursts, bits for plain ones
  assign pd_room  = WORD_W'(is_enhanced ? enh_room : plain_room);
  assign pd_count = is_enhanced ? {1'b0, in_hold[15:1]} : {4'b0, in_hold[15:4]};
  assign clamped  = (pd_count > pd_room) ? pd_room[CNT_W-1:0] : pd_count[CNT_W-1:0];

  assign pay_dec   = (payload_left != '0) ? payload_left - 1'b1 : payload_left;
  assign burst_dec = (burst_left != '0) ? burst_left - 1'b1 : burst_left;

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SEARCH_A: phase_next = (in_hold == SYNC_A) ? PH_SEARCH_B : PH_SEARCH_A;
      PH_SEARCH_B: phase_next = (in_hold == SYNC_B) ? PH_PC : PH_SEARCH_A;
      PH_PC:       phase_next = PH_PD;
      PH_PD: begin
        if (clamped != '0)         phase_next = PH_FIRST;
        else if (pd_room != '0)    phase_next = PH_SKIP;
        else                       phase_next = PH_SEARCH_A;
      end
      PH_FIRST, PH_PAYLOAD: begin
        if (pay_dec != '0)         phase_next = PH_PAYLOAD;
        else if (burst_dec != '0)  phase_next = PH_SKIP;
        else                       phase_next = PH_SEARCH_A;
      end
      PH_SKIP:     phase_next = (burst_dec == '0) ? PH_SEARCH_A : PH_SKIP;
      default:     phase_next = PH_SEARCH_A;
    endcase
  end

  // counters, flags and result
  always_comb begin
    is_enhanced_next  = is_enhanced;
    payload_left_next = payload_left;
    burst_left_next   = burst_left;
    pass_frame_next   = pass_frame;
    emit              = 1'b0;
    case (phase)
      PH_PC: is_enhanced_next = (in_hold == enh_code);
      PH_PD: begin
        burst_left_next   = pd_room[CNT_W-1:0];
        payload_left_next = clamped;
        pass_frame_next   = 1'b0;
      end
      PH_FIRST, PH_PAYLOAD: begin
        if (phase == PH_FIRST) pass_frame_next = (swapped == FRAME_MARK);
        payload_left_next = pay_dec;
        burst_left_next   = burst_dec;
        emit              = pass_frame_next;
      end
      PH_SKIP: burst_left_next = burst_dec;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEARCH_A;
      is_enhanced  <= 1'b0;
      payload_left <= '0;
      burst_left   <= '0;
      pass_frame   <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      is_enhanced  <= is_enhanced_next;
      payload_left <= payload_left_next;
      burst_left   <= burst_left_next;
      pass_frame   <= pass_frame_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_word      <= swapped;
      last_of_frame <= (payload_left_next == '0);
    end
  end

  // payload never outlasts its burst
  a_payload_in_burst: assert property (@(posedge clk) disable iff (rst)
    payload_left <= burst_left)
    else $error("payload count exceeds burst count");

  // payload phase always has words still to come
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (payload_left != '0))
    else $error("payload phase with nothing left");

  // skip phase always has burst words still to come
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (burst_left != '0))
    else $error("skip phase with nothing left");

  // an emitted word lands in the result register and only for a passed burst
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> (out_valid && pass_frame))
    else $error("emitted beat lost or burst not passed");

endmodule
